@@ rtl/bla_pkg.sv @@
// Shared codes, types and reset values for the battery level alarm block.
`timescale 1ns / 1ps

package bla_pkg;

    // Battery level codes.
    localparam logic [1:0] LVL_NORMAL  = 2'd0;
    localparam logic [1:0] LVL_WARNING = 2'd1;
    localparam logic [1:0] LVL_LOW     = 2'd2;
    localparam logic [1:0] LVL_DEAD    = 2'd3;

    // LED command codes.
    localparam logic [1:0] CMD_KEEP   = 2'd0;
    localparam logic [1:0] CMD_ON     = 2'd1;
    localparam logic [1:0] CMD_OFF    = 2'd2;
    localparam logic [1:0] CMD_TOGGLE = 2'd3;

    // Voice prompt codes.
    localparam logic [1:0] VOICE_NONE = 2'd0;
    localparam logic [1:0] VOICE_WARN = 2'd1;
    localparam logic [1:0] VOICE_LOW  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_NORMAL_THR  = 2'd0;
    localparam logic [1:0] REG_WARNING_THR = 2'd1;
    localparam logic [1:0] REG_LOW_THR     = 2'd2;
    localparam logic [1:0] REG_REPEAT_LIM  = 2'd3;

    // Field widths.
    localparam int SAMPLE_W = 12;
    localparam int COUNT_W  = 8;

    // Configuration reset values.
    localparam logic [SAMPLE_W-1:0] NORMAL_THR_RST  = 12'd3000;
    localparam logic [SAMPLE_W-1:0] WARNING_THR_RST = 12'd2800;
    localparam logic [SAMPLE_W-1:0] LOW_THR_RST     = 12'd2600;
    localparam logic [COUNT_W-1:0]  REPEAT_LIM_RST  = 8'd10;

    typedef struct packed {
        logic [SAMPLE_W-1:0] normal_thr;
        logic [SAMPLE_W-1:0] warning_thr;
        logic [SAMPLE_W-1:0] low_thr;
        logic [COUNT_W-1:0]  repeat_lim;
    } bla_cfg_t;

    typedef struct packed {
        logic [1:0]         level;
        logic [COUNT_W-1:0] prompt_cnt;
    } bla_state_t;

    typedef struct packed {
        logic [1:0] level_now;
        logic [1:0] voice_cmd;
        logic [1:0] led_two_cmd;
        logic [1:0] led_one_cmd;
    } bla_result_t;

endpackage

@@ rtl/bla_step.sv @@
// Per-sample level update: threshold compares, LED commands and prompt counter.
`timescale 1ns / 1ps

module bla_step (
    input  logic [bla_pkg::SAMPLE_W-1:0] sample,
    input  bla_pkg::bla_cfg_t            cfg,
    input  bla_pkg::bla_state_t          state_cur,
    output bla_pkg::bla_state_t          state_next,
    output bla_pkg::bla_result_t         result
);

    logic [bla_pkg::COUNT_W-1:0] cnt_inc;

    assign cnt_inc = state_cur.prompt_cnt + {{(bla_pkg::COUNT_W-1){1'b0}}, 1'b1};

    // Level decision; a step down leaves LEDs and voice unchanged.
    always_comb begin
        state_next         = state_cur;
        result.led_one_cmd = bla_pkg::CMD_KEEP;
        result.led_two_cmd = bla_pkg::CMD_KEEP;
        result.voice_cmd   = bla_pkg::VOICE_NONE;
        unique case (state_cur.level)
            bla_pkg::LVL_NORMAL: begin
                if (sample > cfg.normal_thr) begin
                    result.led_one_cmd = bla_pkg::CMD_ON;
                    result.led_two_cmd = bla_pkg::CMD_OFF;
                end else begin
                    state_next.level = bla_pkg::LVL_WARNING;
                end
            end
            bla_pkg::LVL_WARNING: begin
                if (sample > cfg.warning_thr) begin
                    result.led_one_cmd = bla_pkg::CMD_TOGGLE;
                    result.led_two_cmd = bla_pkg::CMD_OFF;
                    // The warning prompt plays once per stay in warning.
                    if (state_cur.prompt_cnt == '0) begin
                        result.voice_cmd      = bla_pkg::VOICE_WARN;
                        state_next.prompt_cnt = {{(bla_pkg::COUNT_W-1){1'b0}}, 1'b1};
                    end
                end else begin
                    state_next.prompt_cnt = '0;
                    state_next.level      = bla_pkg::LVL_LOW;
                end
            end
            bla_pkg::LVL_LOW: begin
                if (sample > cfg.low_thr) begin
                    result.led_one_cmd = bla_pkg::CMD_OFF;
                    result.led_two_cmd = bla_pkg::CMD_ON;
                    // The counter wraps at its width, so a limit at full scale never fires.
                    if (cnt_inc > cfg.repeat_lim) begin
                        result.voice_cmd      = bla_pkg::VOICE_LOW;
                        state_next.prompt_cnt = '0;
                    end else begin
                        state_next.prompt_cnt = cnt_inc;
                    end
                end else begin
                    state_next.prompt_cnt = '0;
                    state_next.level      = bla_pkg::LVL_DEAD;
                end
            end
            default: begin
                result.led_one_cmd = bla_pkg::CMD_OFF;
                result.led_two_cmd = bla_pkg::CMD_OFF;
                state_next.level   = bla_pkg::LVL_DEAD;
            end
        endcase
        result.level_now = state_next.level;
    end

endmodule

@@ rtl/battery_level_alarm_fsm.sv @@
// Top level of the battery level alarm: input register, level update, result register.
`timescale 1ns / 1ps

// Channel   Direction  Item contents
// s_axis    in         one filtered 12-bit battery voltage sample
// m_axis    out        LED one, LED two, voice prompt and level after the step
// cfg       in         thresholds and low-prompt repeat limit, indexed writes
//
// One item per cycle sustained while the output is not stalled; each sample passes through
// the input register, then through the level logic into the result register.
// Level and prompt counter update when a sample moves into the result register.
// A stalled result holds its register; the input register still takes one more item.
// Reset restores normal level, a cleared counter and the default configuration.

module battery_level_alarm_fsm (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] sample, [15:12] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [1:0] led_one_cmd, [3:2] led_two_cmd,
                                   // [5:4] voice_cmd, [7:6] level_now
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [11:0] cfg_wdata
);

    bla_pkg::bla_cfg_t             cfg_reg;
    bla_pkg::bla_state_t           state_reg;
    bla_pkg::bla_state_t           state_next;
    bla_pkg::bla_result_t          result_next;
    bla_pkg::bla_result_t          result_reg;
    logic [bla_pkg::SAMPLE_W-1:0]  sample_reg;
    logic                          in_valid_reg;
    logic                          out_valid_reg;
    logic                          advance;

    // An item moves on when the result register is free or being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.normal_thr  <= bla_pkg::NORMAL_THR_RST;
            cfg_reg.warning_thr <= bla_pkg::WARNING_THR_RST;
            cfg_reg.low_thr     <= bla_pkg::LOW_THR_RST;
            cfg_reg.repeat_lim  <= bla_pkg::REPEAT_LIM_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                bla_pkg::REG_NORMAL_THR:  cfg_reg.normal_thr  <= cfg_wdata;
                bla_pkg::REG_WARNING_THR: cfg_reg.warning_thr <= cfg_wdata;
                bla_pkg::REG_LOW_THR:     cfg_reg.low_thr     <= cfg_wdata;
                bla_pkg::REG_REPEAT_LIM:
                    cfg_reg.repeat_lim <= cfg_wdata[bla_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            sample_reg <= s_tdata[bla_pkg::SAMPLE_W-1:0];
        end
    end

    bla_step u_step (
        .sample     (sample_reg),
        .cfg        (cfg_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Level state and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                state_reg <= state_next;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

endmodule

@@ dv/tb_battery_level_alarm_fsm.sv @@
// Self-checking testbench for the battery level alarm: directed table, then random level phases.
`timescale 1ns / 1ps

module tb_battery_level_alarm_fsm;

    localparam int CYCLE_LIMIT = 100000;
    localparam int HOLD_CYCLES = 300;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [11:0] sample, [15:12] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [1:0] led_one_cmd, [3:2] led_two_cmd,
                            // [5:4] voice_cmd, [7:6] level_now
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [11:0] cfg_wdata;

    // One row of the directed table: a sample and, where obvious, its typed result.
    typedef struct {
        logic [bla_pkg::SAMPLE_W-1:0] smp;
        bit                           typed;
        bla_pkg::bla_result_t         want;
    } sample_row_t;

    // Shadow configuration and level state of the alarm.
    logic [bla_pkg::SAMPLE_W-1:0] thr_normal;
    logic [bla_pkg::SAMPLE_W-1:0] thr_warning;
    logic [bla_pkg::SAMPLE_W-1:0] thr_low;
    logic [bla_pkg::COUNT_W-1:0]  rpt_limit;
    logic [1:0]                   cur_level;
    logic [bla_pkg::COUNT_W-1:0]  prompt_cnt;

    bla_pkg::bla_result_t pending_alarms[$];
    int                   samples_sent;
    int                   mismatch_count;
    int                   cycle_count;
    int                   src_idle_pct;
    int                   rcv_idle_pct;
    int                   hold_left;
    bit                   hold_done;

    battery_level_alarm_fsm DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // 100 MHz clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Step the shadow level machine by one sample and return the alarm it produces.
    function automatic bla_pkg::bla_result_t next_alarm_result(
        input logic [bla_pkg::SAMPLE_W-1:0] smp);
        bla_pkg::bla_result_t r;
        r.led_one_cmd = bla_pkg::CMD_KEEP;
        r.led_two_cmd = bla_pkg::CMD_KEEP;
        r.voice_cmd   = bla_pkg::VOICE_NONE;
        case (cur_level)
            bla_pkg::LVL_NORMAL: begin
                if (smp > thr_normal) begin
                    r.led_one_cmd = bla_pkg::CMD_ON;
                    r.led_two_cmd = bla_pkg::CMD_OFF;
                end else begin
                    cur_level = bla_pkg::LVL_WARNING;
                end
            end
            bla_pkg::LVL_WARNING: begin
                if (smp > thr_warning) begin
                    r.led_one_cmd = bla_pkg::CMD_TOGGLE;
                    r.led_two_cmd = bla_pkg::CMD_OFF;
                    if (prompt_cnt == '0) begin
                        r.voice_cmd = bla_pkg::VOICE_WARN;
                        prompt_cnt  = 8'd1;
                    end
                end else begin
                    prompt_cnt = '0;
                    cur_level  = bla_pkg::LVL_LOW;
                end
            end
            bla_pkg::LVL_LOW: begin
                if (smp > thr_low) begin
                    r.led_one_cmd = bla_pkg::CMD_OFF;
                    r.led_two_cmd = bla_pkg::CMD_ON;
                    prompt_cnt    = prompt_cnt + 8'd1;
                    if (prompt_cnt > rpt_limit) begin
                        r.voice_cmd = bla_pkg::VOICE_LOW;
                        prompt_cnt  = '0;
                    end
                end else begin
                    prompt_cnt = '0;
                    cur_level  = bla_pkg::LVL_DEAD;
                end
            end
            default: begin
                r.led_one_cmd = bla_pkg::CMD_OFF;
                r.led_two_cmd = bla_pkg::CMD_OFF;
                cur_level     = bla_pkg::LVL_DEAD;
            end
        endcase
        r.level_now = cur_level;
        return r;
    endfunction

    // Write one register; the shadow copy keeps only the register's own width.
    task automatic cfg_write(input logic [1:0] addr, input logic [11:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        case (addr)
            bla_pkg::REG_NORMAL_THR:  thr_normal  = data;
            bla_pkg::REG_WARNING_THR: thr_warning = data;
            bla_pkg::REG_LOW_THR:     thr_low     = data;
            default:                  rpt_limit   = data[bla_pkg::COUNT_W-1:0];
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Offer one sample, with random gaps, and record its alarm once accepted.
    task automatic send_sample(input logic [bla_pkg::SAMPLE_W-1:0] smp, input bit typed,
                               input bla_pkg::bla_result_t typed_want);
        bla_pkg::bla_result_t want;
        if (samples_sent < 320) begin
            src_idle_pct = 31;
            rcv_idle_pct = 76;
        end else if (samples_sent < 640) begin
            src_idle_pct = 76;
            rcv_idle_pct = 31;
        end else begin
            src_idle_pct = 0;
            rcv_idle_pct = 0;
        end
        while ($urandom_range(99, 0) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, smp};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        want = next_alarm_result(smp);
        pending_alarms.push_back(typed ? typed_want : want);
        samples_sent++;
        @(negedge aclk);
    endtask

    // Stay in the current level: every sample lies above the given threshold.
    task automatic stay_in_level(input int count, input int thr);
        logic [bla_pkg::SAMPLE_W-1:0] smp;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(15, 0) == 0)
                smp = 12'(thr + 1);
            else
                smp = 12'($urandom_range(4095, thr + 1));
            send_sample(smp, 1'b0, '0);
        end
    endtask

    // Let the block go idle before touching its registers.
    task automatic drain_alarms();
        s_tvalid <= 1'b0;
        while (pending_alarms.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Receiver: random stalls, plus one long hold-off to back the block up.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && samples_sent >= 450) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= rcv_idle_pct);
        end
    end

    // Compare each accepted alarm with the oldest expected one.
    always @(posedge aclk) begin : check_alarm
        bla_pkg::bla_result_t got;
        bla_pkg::bla_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_alarms.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: alarm %h arrived with none expected", $realtime, got);
            end else begin
                want = pending_alarms.pop_front();
                if (got.led_one_cmd != want.led_one_cmd ||
                    got.led_two_cmd != want.led_two_cmd ||
                    got.voice_cmd   != want.voice_cmd   ||
                    got.level_now   != want.level_now) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: l1/l2/vc/lvl exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 $realtime, want.led_one_cmd, want.led_two_cmd,
                                 want.voice_cmd, want.level_now, got.led_one_cmd,
                                 got.led_two_cmd, got.voice_cmd, got.level_now);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Stimulus: directed table in normal and warning, then random phases down to dead.
    initial begin : stimulus
        sample_row_t          directed_rows [9];
        bla_pkg::bla_result_t normal_on;
        int                   thr;
        normal_on = '{level_now: bla_pkg::LVL_NORMAL, voice_cmd: bla_pkg::VOICE_NONE,
                      led_two_cmd: bla_pkg::CMD_OFF, led_one_cmd: bla_pkg::CMD_ON};
        directed_rows[0] = '{12'd4095, 1'b1, normal_on};
        directed_rows[1] = '{12'd3001, 1'b1, normal_on};
        directed_rows[2] = '{12'hBFF,  1'b1, normal_on};
        directed_rows[3] = '{12'hD55,  1'b1, normal_on};
        directed_rows[4] = '{12'hEAA,  1'b1, normal_on};
        // Sample equal to the threshold steps down with everything unchanged.
        directed_rows[5] = '{12'd3000, 1'b1,
                             '{level_now: bla_pkg::LVL_WARNING, voice_cmd: bla_pkg::VOICE_NONE,
                               led_two_cmd: bla_pkg::CMD_KEEP, led_one_cmd: bla_pkg::CMD_KEEP}};
        // First sample held in warning plays the warning prompt once.
        directed_rows[6] = '{12'd4095, 1'b1,
                             '{level_now: bla_pkg::LVL_WARNING, voice_cmd: bla_pkg::VOICE_WARN,
                               led_two_cmd: bla_pkg::CMD_OFF, led_one_cmd: bla_pkg::CMD_TOGGLE}};
        directed_rows[7] = '{12'd2801, 1'b1,
                             '{level_now: bla_pkg::LVL_WARNING, voice_cmd: bla_pkg::VOICE_NONE,
                               led_two_cmd: bla_pkg::CMD_OFF, led_one_cmd: bla_pkg::CMD_TOGGLE}};
        directed_rows[8] = '{12'hC00,  1'b0, '0};

        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = bla_pkg::REG_NORMAL_THR;
        cfg_wdata    = '0;
        thr_normal   = bla_pkg::NORMAL_THR_RST;
        thr_warning  = bla_pkg::WARNING_THR_RST;
        thr_low      = bla_pkg::LOW_THR_RST;
        rpt_limit    = bla_pkg::REPEAT_LIM_RST;
        cur_level    = bla_pkg::LVL_NORMAL;
        prompt_cnt   = '0;
        src_idle_pct = 31;
        rcv_idle_pct = 76;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i])
            send_sample(directed_rows[i].smp, directed_rows[i].typed, directed_rows[i].want);

        // Warning with the threshold at zero, then at a random value.
        drain_alarms();
        cfg_write(bla_pkg::REG_NORMAL_THR, 12'd4095);
        cfg_write(bla_pkg::REG_NORMAL_THR, 12'd0);
        cfg_write(bla_pkg::REG_WARNING_THR, 12'd0);
        stay_in_level(90, 0);
        drain_alarms();
        thr = $urandom_range(3500, 1000);
        cfg_write(bla_pkg::REG_WARNING_THR, 12'(thr));
        stay_in_level(90, thr);

        // Top threshold forces the step into low; low prompt on every sample.
        drain_alarms();
        cfg_write(bla_pkg::REG_REPEAT_LIM, 12'd0);
        cfg_write(bla_pkg::REG_WARNING_THR, 12'd4095);
        send_sample(12'($urandom_range(4095, 0)), 1'b0, '0);
        stay_in_level(80, int'(bla_pkg::LOW_THR_RST));

        // Limit of 255: the counter wraps and the prompt never plays.
        drain_alarms();
        cfg_write(bla_pkg::REG_LOW_THR, 12'd0);
        cfg_write(bla_pkg::REG_REPEAT_LIM, 12'd255);
        stay_in_level(300, 0);

        // Upper bits of the written limit are dropped, leaving three.
        drain_alarms();
        thr = $urandom_range(3000, 100);
        cfg_write(bla_pkg::REG_REPEAT_LIM, 12'hF03);
        cfg_write(bla_pkg::REG_LOW_THR, 12'(thr));
        stay_in_level(150, thr);
        drain_alarms();
        cfg_write(bla_pkg::REG_REPEAT_LIM, 12'd1);
        stay_in_level(100, thr);
        drain_alarms();
        thr = $urandom_range(3800, 1);
        cfg_write(bla_pkg::REG_REPEAT_LIM, 12'($urandom_range(20, 2)));
        cfg_write(bla_pkg::REG_LOW_THR, 12'(thr));
        stay_in_level(60, thr);

        // Into dead, where any sample keeps both LEDs off.
        drain_alarms();
        cfg_write(bla_pkg::REG_LOW_THR, 12'd4095);
        send_sample(12'($urandom_range(4095, 0)), 1'b0, '0);
        for (int i = 0; i < 40; i++)
            send_sample(12'($urandom_range(4095, 0)), 1'b0, '0);
        drain_alarms();
        cfg_write(bla_pkg::REG_NORMAL_THR, 12'($urandom_range(4095, 0)));
        cfg_write(bla_pkg::REG_WARNING_THR, 12'($urandom_range(4095, 0)));
        cfg_write(bla_pkg::REG_LOW_THR, 12'($urandom_range(4095, 0)));
        cfg_write(bla_pkg::REG_REPEAT_LIM, 12'($urandom_range(255, 1)));
        for (int i = 0; i < 40; i++)
            send_sample(12'($urandom_range(4095, 0)), 1'b0, '0);

        drain_alarms();
        if (mismatch_count == 0 && pending_alarms.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
